### hdl/minv_pkg.sv
// Shared types and constants for the modular inverse block.
package minv_pkg;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_IDLE  = 2'd0;
  localparam phase_t PH_ALIGN = 2'd1;
  localparam phase_t PH_SUB   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hdl/minv_div.sv
// Shift-subtract divider that also accumulates quotient times a cofactor.
module minv_div
  import minv_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] n,
  input  logic [W-1:0] d,
  input  logic [W-1:0] tm_in,
  output div_status_t  status,
  output logic [W-1:0] rem,
  output logic [W-1:0] acc
);

  localparam int CW = $clog2(W);

  phase_t        phase;
  logic          done;
  logic [W-1:0]  ds;
  logic [W-1:0]  tm;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ds_dbl;
  logic          ge;
  logic [W-1:0]  acc_next;

  assign ds_dbl   = {ds[W-2:0], 1'b0};
  assign ge       = (rem >= ds);
  assign acc_next = {acc[W-2:0], 1'b0} + (ge ? tm : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            rem   <= n;
            ds    <= d;
            tm    <= tm_in;
            acc   <= '0;
            cnt   <= '0;
            phase <= PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          if (!ds[W-1] && (ds_dbl <= rem)) begin
            ds  <= ds_dbl;
            cnt <= cnt + CW'(1);
          end else begin
            phase <= PH_SUB;
          end
        end
        PH_SUB: begin
          if (ge) begin
            rem <= rem - ds;
          end
          acc <= acc_next;
          ds  <= {1'b0, ds[W-1:1]};
          if (cnt == '0) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  assign status.busy = (phase != PH_IDLE);
  assign status.done = done;

endmodule

### hdl/modular_inverse.sv
// Top level of the modular inverse block: extended Euclid around a shared divider.
// Latency per transaction is data dependent: each Euclid step takes one division whose length
// grows with the bit length of that step's quotient, and one reduction division comes first;
// all of it runs on the single shift-subtract unit.
// One transaction is in flight at a time; a finished result may wait while the next is taken.
// The synchronous reset clears the sequencer, the divider and the result valid.
module modular_inverse
  import minv_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] value,
  input  logic [31:0] modulus,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] inverse,
  output logic        not_invertible
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_LOOP   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

  logic [2:0]        state;
  logic [WIDTH-1:0]  modreg;
  logic [WIDTH-1:0]  r0;
  logic [WIDTH-1:0]  r1;
  logic [WIDTH-1:0]  t0;
  logic [WIDTH-1:0]  t1;
  logic              idx;
  logic [WIDTH+31:0] value_ext;
  logic [WIDTH+31:0] modulus_ext;
  logic [WIDTH-1:0]  value_w;
  logic [WIDTH-1:0]  modulus_w;
  logic              accept;
  logic              div_start;
  logic [WIDTH-1:0]  div_n;
  logic [WIDTH-1:0]  div_d;
  logic [WIDTH-1:0]  div_t;
  div_status_t       div_st;
  logic [WIDTH-1:0]  div_rem;
  logic [WIDTH-1:0]  div_acc;
  logic [WIDTH-1:0]  t_red;
  logic [WIDTH-1:0]  inv_w;
  logic [WIDTH+31:0] inv_ext;
  logic              out_free;

  assign value_ext   = {{WIDTH{1'b0}}, value};
  assign modulus_ext = {{WIDTH{1'b0}}, modulus};
  assign value_w     = value_ext[WIDTH-1:0];
  assign modulus_w   = modulus_ext[WIDTH-1:0];

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);

  assign div_start = !div_st.busy &&
                     ((accept && (modulus_w != '0)) || ((state == S_LOOP) && (r1 != '0)));
  assign div_n     = (state == S_IDLE) ? value_w : r0;
  assign div_d     = (state == S_IDLE) ? modulus_w : r1;
  assign div_t     = (state == S_IDLE) ? '0 : t1;

  minv_div #(
    .W(WIDTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .tm_in (div_t),
    .status(div_st),
    .rem   (div_rem),
    .acc   (div_acc)
  );

  // The final cofactor is negative when the step count is even.
  assign t_red   = (t0 == modreg) ? '0 : t0;
  assign inv_w   = (r0 != ONE) ? '0 : ((idx || (t_red == '0)) ? t_red : modreg - t_red);
  assign inv_ext = {32'd0, inv_w};

  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            modreg <= modulus_w;
            if (modulus_w == '0) begin
              r0    <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (div_st.done) begin
            r0    <= modreg;
            r1    <= div_rem;
            t0    <= '0;
            t1    <= ONE;
            idx   <= 1'b0;
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (r1 == '0) begin
            state <= S_FINISH;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            r0    <= r1;
            r1    <= div_rem;
            t0    <= t1;
            t1    <= t0 + div_acc;
            idx   <= !idx;
            state <= S_LOOP;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            inverse        <= inv_ext[31:0];
            not_invertible <= (r0 != ONE);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/minv_checker.sv
// Port-level checks for the modular inverse block and their binding to the top level.
module minv_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [31:0] value,
  input logic [31:0] modulus,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [31:0] inverse,
  input logic        not_invertible
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(inverse) && $stable(not_invertible))
    else $error("Stalled result changed or was dropped.");

  a_noinv_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && not_invertible |-> inverse == 32'd0)
    else $error("Result flagged not invertible carries a non-zero inverse.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("Block took a transaction without becoming busy.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("Reset did not clear the result valid or the busy state.");

endmodule

bind modular_inverse minv_checker u_minv_checker (.*);

### bench/modular_inverse_tb.sv
// Self-checking testbench for the modular inverse block, with a stall-based handshake on both sides.
module modular_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int unsigned {
    FLOW_FREE,
    FLOW_SPARSE_SEND,
    FLOW_SLOW_SINK,
    FLOW_BOTH_IDLE
  } flow_t;

  typedef struct {
    logic [31:0] value;
    logic [31:0] modulus;
    flow_t       flow;
    bit          drain;
  } operand_t;

  typedef struct {
    logic [31:0] inverse;
    logic        not_invertible;
  } inverse_t;

  localparam int unsigned SEND_IDLE_PCT[4] = '{0, 82, 0, 24};
  localparam int unsigned SINK_STALL_PCT[4] = '{0, 0, 82, 24};
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned SETTLE_CYCLES = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [31:0] value = '0;
  logic [31:0] modulus = 32'd1;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] inverse;
  logic        not_invertible;

  operand_t    pending_operands[$];
  inverse_t    awaited_inverses[$];
  flow_t       active_flow = FLOW_FREE;
  int unsigned mismatches = 0;

  modular_inverse dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .value          (value),
    .modulus        (modulus),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .inverse        (inverse),
    .not_invertible (not_invertible)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic inverse_t euclid_inverse(input logic [31:0] a, input logic [31:0] m);
    logic [63:0] r_prev, r_cur, t_prev, t_cur, quot, r_next, t_next;
    int unsigned steps;
    inverse_t    res;
    res.inverse = '0;
    res.not_invertible = 1'b1;
    if (m == '0) begin
      return res;
    end
    r_prev = {32'd0, m};
    r_cur  = {32'd0, a % m};
    t_prev = 64'd0;
    t_cur  = 64'd1;
    steps  = 0;
    while (r_cur != 64'd0) begin
      quot   = r_prev / r_cur;
      r_next = r_prev - quot * r_cur;
      t_next = t_prev + quot * t_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
      steps++;
    end
    if (r_prev != 64'd1) begin
      return res;
    end
    // Cofactor signs alternate, so an even step count means a negative cofactor.
    t_prev = t_prev % {32'd0, m};
    if (steps[0] || t_prev == 64'd0) begin
      res.inverse = t_prev[31:0];
    end else begin
      res.inverse = m - t_prev[31:0];
    end
    res.not_invertible = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin : drive
    operand_t next_op;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        awaited_inverses.push_back(euclid_inverse(value, modulus));
      end
      if (!req_valid || !req_stall) begin
        req_valid <= 1'b0;
        if (pending_operands.size() != 0) begin
          next_op = pending_operands[0];
          if (!(next_op.drain && awaited_inverses.size() != 0) &&
              $urandom_range(99) >= SEND_IDLE_PCT[next_op.flow]) begin
            void'(pending_operands.pop_front());
            value       <= next_op.value;
            modulus     <= next_op.modulus;
            req_valid   <= 1'b1;
            active_flow <= next_op.flow;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : observe
    inverse_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_inverses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected transaction: inverse %h not_invertible %b",
                     inverse, not_invertible);
          end
        end else begin
          want = awaited_inverses.pop_front();
          if (inverse !== want.inverse || not_invertible !== want.not_invertible) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected inverse %h not_invertible %b, got %h %b",
                       want.inverse, want.not_invertible, inverse, not_invertible);
            end
          end
        end
      end
      rsp_stall <= ($urandom_range(99) < SINK_STALL_PCT[active_flow]);
    end
  end

  task automatic add_operand(input logic [31:0] a, input logic [31:0] m, input flow_t flow,
                             input bit drain);
    operand_t op;
    op.value   = a;
    op.modulus = m;
    op.flow    = flow;
    op.drain   = drain;
    pending_operands.push_back(op);
  endtask

  initial begin : stimulus
    logic [31:0] a, m, g;
    flow_t       flow;
    int unsigned pick;
    add_operand(32'd0, 32'd1, FLOW_FREE, 1'b0);
    add_operand(32'd5, 32'd1, FLOW_FREE, 1'b0);
    add_operand(32'hFFFF_FFFF, 32'd1, FLOW_FREE, 1'b0);
    add_operand(32'd0, 32'd7, FLOW_FREE, 1'b0);
    add_operand(32'd3, 32'd7, FLOW_FREE, 1'b0);
    add_operand(32'd10, 32'd7, FLOW_FREE, 1'b0);
    add_operand(32'd7, 32'd7, FLOW_FREE, 1'b0);
    add_operand(32'd14, 32'd21, FLOW_FREE, 1'b0);
    add_operand(32'd1, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'hFFFF_FFFE, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'hFFFF_FFFF, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'hFFFF_FFFF, 32'hFFFF_FFFE, FLOW_FREE, 1'b0);
    add_operand(32'd2, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'd2, 32'hFFFF_FFFE, FLOW_FREE, 1'b0);
    add_operand(32'd0, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'h8000_0000, 32'hFFFF_FFFF, FLOW_FREE, 1'b0);
    add_operand(32'd1836311903, 32'd2971215073, FLOW_FREE, 1'b0);
    add_operand(32'd2971215073, 32'd1836311903, FLOW_FREE, 1'b0);
    add_operand(32'd12345, 32'd2, FLOW_FREE, 1'b0);
    add_operand(32'd1, 32'd2, FLOW_FREE, 1'b0);
    add_operand(32'hAAAA_AAAA, 32'h5555_5555, FLOW_FREE, 1'b0);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      flow = flow_t'((i / 190) % 4);
      pick = $urandom_range(99);
      a = $urandom();
      m = $urandom();
      if (pick < 50) begin
        // Full-width operands.
      end else if (pick < 70) begin
        m = m >> $urandom_range(31);
        a = a >> $urandom_range(31);
      end else if (pick < 80) begin
        m = $urandom_range(1000, 1);
      end else if (pick < 92) begin
        // Force a shared factor.
        g = $urandom_range(64, 2);
        m = (m >> 7) * g;
        a = (a >> 7) * g;
      end else begin
        a = m - $urandom_range(3);
      end
      if (m == '0) begin
        m = 32'd1;
      end
      add_operand(a, m, flow, (i % 190) == 0);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_operands.size() != 0 || req_valid) @(posedge clk);
    while (awaited_inverses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
